@@ hw/rtl/pcds_pkg.sv @@
// ----------------------------------------------------------------------------
// pcds_pkg
// Shared types, constants and helpers for the point/center distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcds_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int MAX_DIMS    = 16;
  localparam int COORD_BITS  = 16;

  localparam int CTR_W  = $clog2(MAX_CENTERS);
  localparam int DIM_W  = $clog2(MAX_DIMS);
  localparam int ADDR_W = CTR_W + DIM_W;
  localparam int CNT_W  = 5;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int SUM_W  = 37;
  localparam int DIST_W = 36;
  localparam int IDX_W  = 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [IDX_W-1:0] REG_CENTERS = 1'd0;
  localparam logic [IDX_W-1:0] REG_DIMS    = 1'd1;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } pcds_state_t;

  // command bundle from controller to datapath
  typedef struct packed {
    logic             ld_center;
    logic             ld_point;
    logic             rd_en;
    logic [CTR_W-1:0] rd_ctr;
    logic             acc_en;
    logic [CTR_W-1:0] acc_ctr;
    logic             acc_first;
    logic             acc_final;
    logic             acc_emit;
    logic             acc_last;
  } pcds_ctl_t;

  // zero counts as one, anything above the limit saturates
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pcds_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcds_ctrl
// Controller: config registers, command decode and the per-point sequencer
// that walks all centers through the read / square / accumulate stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pcds_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          in_operation,
  input  wire logic [pcds_pkg::DIM_W-1:0]    in_dim_index,
  input  wire logic                          cfg_valid,
  input  wire logic [pcds_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [pcds_pkg::CNT_W-1:0]    cfg_data,
  output pcds_pkg::pcds_ctl_t                ctl,
  output logic                               busy,
  output logic                               out_strobe
);

  pcds_pkg::pcds_state_t state_r, state_nxt;

  logic [pcds_pkg::CNT_W-1:0] centers_r, dims_r;
  logic [pcds_pkg::CNT_W-1:0] k_cl, d_cl;
  logic [pcds_pkg::CNT_W-1:0] k_r, k_nxt;
  logic                       first_r, first_nxt;
  logic                       final_r, final_nxt;
  logic [pcds_pkg::CTR_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic                       s1_vld_r, s2_vld_r;
  logic [pcds_pkg::CTR_W-1:0] s1_ctr_r, s2_ctr_r;
  logic                       out_strobe_r;
  logic                       accept;
  logic                       pt_go;

  assign k_cl = pcds_pkg::clamp_count(centers_r, pcds_pkg::CNT_W'(pcds_pkg::MAX_CENTERS));
  assign d_cl = pcds_pkg::clamp_count(dims_r, pcds_pkg::CNT_W'(pcds_pkg::MAX_DIMS));

  assign busy   = (state_r != pcds_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign pt_go  = accept && (in_operation == pcds_pkg::OP_POINT) &&
                  ({1'b0, in_dim_index} < d_cl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centers_r <= pcds_pkg::CNT_RESET;
      dims_r    <= pcds_pkg::CNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcds_pkg::REG_CENTERS: centers_r <= cfg_data;
        pcds_pkg::REG_DIMS:    dims_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pcds_pkg::ST_IDLE;
      rd_cnt_r     <= '0;
      k_r          <= pcds_pkg::CNT_RESET;
      first_r      <= 1'b0;
      final_r      <= 1'b0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s1_ctr_r     <= '0;
      s2_ctr_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      k_r          <= k_nxt;
      first_r      <= first_nxt;
      final_r      <= final_nxt;
      s1_vld_r     <= ctl.rd_en;
      s1_ctr_r     <= ctl.rd_ctr;
      s2_vld_r     <= s1_vld_r;
      s2_ctr_r     <= s1_ctr_r;
      out_strobe_r <= ctl.acc_emit;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    k_nxt      = k_r;
    first_nxt  = first_r;
    final_nxt  = final_r;

    ctl           = '0;
    ctl.ld_center = accept && (in_operation == pcds_pkg::OP_LOAD);
    ctl.ld_point  = pt_go;
    ctl.rd_ctr    = rd_cnt_r;
    ctl.acc_en    = s2_vld_r;
    ctl.acc_ctr   = s2_ctr_r;
    ctl.acc_first = first_r;
    ctl.acc_final = final_r;
    ctl.acc_emit  = s2_vld_r && final_r && ({1'b0, s2_ctr_r} < k_r);
    ctl.acc_last  = ({1'b0, s2_ctr_r} == k_r - pcds_pkg::CNT_W'(1));

    unique case (state_r)
      pcds_pkg::ST_IDLE: begin
        if (pt_go) begin
          state_nxt  = pcds_pkg::ST_ISSUE;
          rd_cnt_nxt = '0;
          k_nxt      = k_cl;
          first_nxt  = (in_dim_index == '0);
          final_nxt  = ({1'b0, in_dim_index} == d_cl - pcds_pkg::CNT_W'(1));
        end
      end
      pcds_pkg::ST_ISSUE: begin
        ctl.rd_en  = 1'b1;
        rd_cnt_nxt = rd_cnt_r + pcds_pkg::CTR_W'(1);
        if (rd_cnt_r == pcds_pkg::CTR_W'(pcds_pkg::MAX_CENTERS - 1)) begin
          state_nxt = pcds_pkg::ST_DRAIN;
        end
      end
      pcds_pkg::ST_DRAIN: begin
        // wait for the square and accumulate stages to empty
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = pcds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcds_pkg::ST_IDLE;
    endcase
  end

  assign out_strobe = out_strobe_r;

endmodule

`default_nettype wire

@@ hw/rtl/pcds_dpath.sv @@
// ----------------------------------------------------------------------------
// pcds_dpath
// Datapath: center table memory, difference/square stage and the per-center
// running sums with the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pcds_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pcds_pkg::pcds_ctl_t                ctl,
  input  wire logic [pcds_pkg::CTR_W-1:0]         in_center_slot,
  input  wire logic [pcds_pkg::DIM_W-1:0]         in_dim_index,
  input  wire logic signed [pcds_pkg::COORD_BITS-1:0] in_coord_value,
  output logic [pcds_pkg::CTR_W-1:0]              out_center_id,
  output logic [pcds_pkg::DIST_W-1:0]             out_distance_sq,
  output logic                                    out_last_of_point
);

  localparam int DEPTH = pcds_pkg::MAX_CENTERS * pcds_pkg::MAX_DIMS;

  logic [pcds_pkg::COORD_BITS-1:0] ctab_mem [DEPTH];
  logic [pcds_pkg::COORD_BITS-1:0] cdata_r;
  logic [pcds_pkg::COORD_BITS-1:0] p_r;
  logic [pcds_pkg::DIM_W-1:0]      dim_r;
  logic [pcds_pkg::SQ_W-1:0]       sq_r;
  logic [pcds_pkg::SUM_W-1:0]      sum_r [pcds_pkg::MAX_CENTERS];

  logic signed [pcds_pkg::DIFF_W-1:0] diff;
  logic signed [pcds_pkg::PROD_W-1:0] prod;
  logic [pcds_pkg::SUM_W-1:0]         sum_old;
  logic [pcds_pkg::SUM_W-1:0]         sum_new;

  logic [pcds_pkg::CTR_W-1:0]  out_center_id_r;
  logic [pcds_pkg::DIST_W-1:0] out_distance_sq_r;
  logic                        out_last_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_center) begin
      ctab_mem[{in_center_slot, in_dim_index}] <= in_coord_value;
    end
    if (ctl.rd_en) begin
      cdata_r <= ctab_mem[{ctl.rd_ctr, dim_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_point) begin
      p_r   <= in_coord_value;
      dim_r <= in_dim_index;
    end
  end

  // difference is exact in one extra bit; square is non-negative
  assign diff = $signed({p_r[pcds_pkg::COORD_BITS-1], p_r}) -
                $signed({cdata_r[pcds_pkg::COORD_BITS-1], cdata_r});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    sq_r <= prod[pcds_pkg::SQ_W-1:0];
  end

  assign sum_old = ctl.acc_first ? '0 : sum_r[ctl.acc_ctr];
  assign sum_new = sum_old + pcds_pkg::SUM_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pcds_pkg::MAX_CENTERS; i++) begin
        sum_r[i] <= '0;
      end
    end else if (ctl.acc_en) begin
      // last coordinate of a point leaves the sums cleared
      sum_r[ctl.acc_ctr] <= ctl.acc_final ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_emit) begin
      out_center_id_r   <= ctl.acc_ctr;
      out_distance_sq_r <= sum_new[pcds_pkg::DIST_W-1:0];
      out_last_r        <= ctl.acc_last;
    end
  end

  assign out_center_id     = out_center_id_r;
  assign out_distance_sq   = out_distance_sq_r;
  assign out_last_of_point = out_last_r;

endmodule

`default_nettype wire

@@ hw/rtl/point_center_distance_sq_core.sv @@
// ----------------------------------------------------------------------------
// point_center_distance_sq_core
// Squared Euclidean distance from streamed points to a table of centers.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken when start is high and busy is low. A load word
//   (in_operation = 0) writes one center coordinate and is done in the
//   accepting cycle; busy stays low. A point word (in_operation = 1) with
//   in_dim_index below dims_in_use runs all 16 centers through a shared
//   read / square / accumulate pipe: busy stays high until the pipe has
//   drained, so no new word is taken while a point is running. Point words
//   with in_dim_index at or beyond dims_in_use are dropped.
//   After the point's last coordinate, one word per center in use comes out
//   on consecutive cycles, each marked by out_strobe for one cycle;
//   out_last_of_point marks the final one.
//   The receiver cannot stall the output; words must be taken as shown.
//   Configuration (cfg_index 0 = centers_in_use, 1 = dims_in_use) is always
//   ready; the user must write it only while the block is idle, as the
//   block does not enforce this. Reset sets both counts to 16 and clears
//   the running sums; the center table holds garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module point_center_distance_sq_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   in_operation,
  input  wire logic [pcds_pkg::CTR_W-1:0]             in_center_slot,
  input  wire logic [pcds_pkg::DIM_W-1:0]             in_dim_index,
  input  wire logic signed [pcds_pkg::COORD_BITS-1:0] in_coord_value,
  output logic                                        out_strobe,
  output logic [pcds_pkg::CTR_W-1:0]                  out_center_id,
  output logic [pcds_pkg::DIST_W-1:0]                 out_distance_sq,
  output logic                                        out_last_of_point,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pcds_pkg::IDX_W-1:0]             cfg_index,
  input  wire logic [pcds_pkg::CNT_W-1:0]             cfg_data
);

  pcds_pkg::pcds_ctl_t ctl;

  assign cfg_ready = 1'b1;

  pcds_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_dim_index (in_dim_index),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctl          (ctl),
    .busy         (busy),
    .out_strobe   (out_strobe)
  );

  pcds_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_center_slot    (in_center_slot),
    .in_dim_index      (in_dim_index),
    .in_coord_value    (in_coord_value),
    .out_center_id     (out_center_id),
    .out_distance_sq   (out_distance_sq),
    .out_last_of_point (out_last_of_point)
  );

`ifndef NO_ASSERTIONS
  // results only come out of a point run: while busy is high or in the cycle after it drops
  a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (busy || $past(busy)))
    else $error("result word outside a point run");

  // results of one point are back to back with rising center ids
  a_ids_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_point) |=>
      (out_strobe && (out_center_id ==
        pcds_pkg::CTR_W'($past(out_center_id) + pcds_pkg::CTR_W'(1)))))
    else $error("gap or misordered center in result burst");

  // the marked word closes the burst
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_of_point) |=> !out_strobe)
    else $error("result word after last_of_point");
`endif

endmodule

`default_nettype wire
